[hw/rtl/mwo_pkg.sv]
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants of the multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

  typedef enum logic [2:0] {
    MODE_SINE  = 3'd0,
    MODE_TRI   = 3'd1,
    MODE_PULSE = 3'd2,
    MODE_SAW   = 3'd3,
    MODE_USER  = 3'd4
  } mode_t;

  localparam logic [2:0] REG_WAVE_MODE  = 3'd0;
  localparam logic [2:0] REG_DUTY_WIDTH = 3'd1;
  localparam logic [2:0] REG_RATE_HZ    = 3'd2;
  localparam logic [2:0] REG_LEVEL_RNG  = 3'd3;
  localparam logic [2:0] REG_HARM_LO    = 3'd4;
  localparam logic [2:0] REG_HARM_HI    = 3'd5;
  localparam logic [2:0] REG_USER_LO    = 3'd6;
  localparam logic [2:0] REG_USER_HI    = 3'd7;

  // Q28 Taylor coefficients of sin(pi*z/2)
  localparam logic [28:0] SC_A = 29'd421657428;
  localparam logic [28:0] SC_B = 29'd173399667;
  localparam logic [28:0] SC_C = 29'd21392326;
  localparam logic [28:0] SC_D = 29'd1256749;
  localparam logic [28:0] SC_E = 29'd43068;

  localparam logic [16:0] Q15_ONE = 17'd32768;

  localparam int SINE_LAT = 6;

endpackage

[hw/rtl/mwo_delay.sv]
// ----------------------------------------------------------------------------
// mwo_delay
// Enabled shift line that keeps side data level with a pipelined unit.
// ----------------------------------------------------------------------------
module mwo_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap_r [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    logic [W-1:0] prev;
    if (k == 0) begin : g_first
      assign prev = din;
    end else begin : g_next
      assign prev = tap_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tap_r[k] <= '0;
      end else if (en) begin
        tap_r[k] <= prev;
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

[hw/rtl/mwo_div.sv]
// ----------------------------------------------------------------------------
// mwo_div
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// The dividend must stay below den << QW.
// ----------------------------------------------------------------------------
module mwo_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [XW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [XW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [XW-1:0] trial;
    logic          take;
    if (s == 0) begin : g_first
      assign r_in = XW'(num);
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[s-1];
      assign d_in = den_r[s-1];
      assign q_in = quo_r[s-1];
    end
    assign trial = XW'(d_in) << (QW - 1 - s);
    assign take  = (r_in >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take ? r_in - trial : r_in;
        den_r[s] <= d_in;
        quo_r[s] <= (q_in << 1) | QW'(take);
      end
    end
  end

  assign quo = quo_r[QW-1];
  assign rem = rem_r[QW-1][DW-1:0];

endmodule

[hw/rtl/mwo_sine.sv]
// ----------------------------------------------------------------------------
// mwo_sine
// Sine of a 16-bit phase, Q15, through a six-stage Horner pipeline.
// ----------------------------------------------------------------------------
module mwo_sine
  import mwo_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        phase,
  output logic signed [16:0] sine
);

  logic [16:0] z_c;
  logic [33:0] zz_c;
  logic [16:0] z_r  [5];
  logic [16:0] z2_r [4];
  logic        neg_r [5];
  logic [28:0] t_r  [4];
  logic [45:0] p_c  [4];
  logic [45:0] fin_c;
  logic [16:0] mag_c;

  // odd quadrants run the quarter wave backwards
  always_comb begin
    z_c  = phase[14] ? (Q15_ONE << 1) - {1'b0, phase[13:0], 2'b00}
                     : {1'b0, phase[13:0], 2'b00};
    zz_c = 34'(z_c) * 34'(z_c);
    p_c[0] = 46'(SC_E) * 46'(z2_r[0]);
    p_c[1] = 46'(t_r[0]) * 46'(z2_r[1]);
    p_c[2] = 46'(t_r[1]) * 46'(z2_r[2]);
    p_c[3] = 46'(t_r[2]) * 46'(z2_r[3]);
    fin_c  = 46'(t_r[3]) * 46'(z_r[4]);
    mag_c  = (fin_c[45:29] > Q15_ONE) ? Q15_ONE : fin_c[45:29];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= z_c;
      z2_r[0]  <= zz_c[32:16];
      neg_r[0] <= phase[15];
      t_r[0]   <= SC_D - 29'(p_c[0] >> 16);
      t_r[1]   <= SC_C - 29'(p_c[1] >> 16);
      t_r[2]   <= SC_B - 29'(p_c[2] >> 16);
      t_r[3]   <= SC_A - 29'(p_c[3] >> 16);
      for (int k = 1; k < 5; k++) begin
        z_r[k]   <= z_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        z2_r[k] <= z2_r[k-1];
      end
      sine <= neg_r[4] ? -$signed(mag_c) : $signed(mag_c);
    end
  end

endmodule

[hw/rtl/multi_waveform_oscillator_sample.sv]
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_sample
// Oscillator sample generator: sine blend, triangle, pulse, saw, user wave.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word per cycle unless stalled:
// a sample index and a pitch in sixteenths of a hertz. Result channel
// (out_valid/out_ready) returns one Q15 sample per word, saturated to 18 bits.
// The cfg_ port writes the mode, width, rate, level and table registers; the
// user is to write it only while no words are in flight, which the block
// itself does not enforce. Throughput is one word per cycle unless stalled.
// Between acceptance and out_valid lie the input register, 134 pipeline
// stages set by the sine path (sample and pitch reductions modulo the rate,
// 42-stage divider, harmonic phase dividers, sine polynomial, level sum and the
// blend divider), and the output register. The shaped waveforms run a shorter
// divider chain and are held back in a shift line to meet the sine path.
// On a stall of the receiver the whole pipeline holds; in_ready drops only
// while a finished word waits in the output register with out_ready low.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module multi_waveform_oscillator_sample
  import mwo_pkg::*;
#(
  parameter int WAVE_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_sample_index,
  input  logic [19:0]        in_pitch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_level_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  localparam int IB    = $clog2(WAVE_POINTS);
  localparam int TW    = 16 + IB;
  localparam int LAT_A = 22 + 1 + 32 + IB + 1 + 1 + 34;
  localparam int LAT_B = 32 + 1 + 42 + 4 + 16 + SINE_LAT + 3 + 30;
  localparam logic [TW-1:0] PTS   = TW'(WAVE_POINTS);
  localparam logic [IB-1:0] LAST  = IB'(WAVE_POINTS - 1);

  // configuration
  logic [2:0]   mode_r;
  logic [16:0]  duty_r;
  logic [17:0]  rate_r;
  logic [31:0]  range_r;
  logic [63:0]  hlo_r, hhi_r, ulo_r, uhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SINE;
      duty_r  <= 17'd32768;
      rate_r  <= 18'd44100;
      range_r <= 32'h7FFF_8000;
      hlo_r   <= '0;
      hhi_r   <= '0;
      ulo_r   <= '0;
      uhi_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_MODE:  mode_r  <= cfg_wdata[2:0];
        REG_DUTY_WIDTH: duty_r  <= cfg_wdata[16:0];
        REG_RATE_HZ:    rate_r  <= cfg_wdata[17:0];
        REG_LEVEL_RNG:  range_r <= cfg_wdata[31:0];
        REG_HARM_LO:    hlo_r   <= cfg_wdata;
        REG_HARM_HI:    hhi_r   <= cfg_wdata;
        REG_USER_LO:    ulo_r   <= cfg_wdata;
        REG_USER_HI:    uhi_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  logic [16:0]        wcl;
  logic signed [17:0] vmin, vmax;
  logic [21:0]        dv;
  logic [127:0]       hl, ul;
  logic [11:0]        tot_r;
  logic [10:0]        tot_lo, tot_hi;

  assign wcl  = (duty_r > 17'd65536) ? 17'd65536 : duty_r;
  assign vmin = 18'($signed(range_r[15:0]));
  assign vmax = 18'($signed(range_r[31:16]));
  assign dv   = {rate_r, 4'b0000};
  assign hl   = {hhi_r, hlo_r};
  assign ul   = {uhi_r, ulo_r};

  always_comb begin
    tot_lo = '0;
    tot_hi = '0;
    for (int k = 0; k < 8; k++) begin
      tot_lo = tot_lo + 11'(hlo_r[8*k +: 8]);
      tot_hi = tot_hi + 11'(hhi_r[8*k +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    tot_r <= 12'(tot_lo) + 12'(tot_hi);
  end

  // pipeline control: everything moves unless the output word is stuck
  logic        en;
  logic        v0_r;
  logic [31:0] s0_r;
  logic [19:0] p0_r;
  logic        v_end;
  logic        out_valid_r;
  logic signed [17:0] out_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_sample_index;
      p0_r <= in_pitch;
    end
  end

  mwo_delay #(.W(1), .DEPTH(LAT_B)) u_vdly (
    .clk(clk), .rst_n(rst_n), .en(en), .din(v0_r), .dout(v_end)
  );

  // ---------------- shaped waveforms ----------------
  logic [21:0] quo1;
  logic [31:0] s_d1;

  mwo_div #(.NW(22), .DW(20), .QW(22)) u_div_per (
    .clk(clk), .en(en), .num(dv), .den(p0_r), .quo(quo1), .rem()
  );

  mwo_delay #(.W(32), .DEPTH(22)) u_sdly (
    .clk(clk), .rst_n(rst_n), .en(en), .din(s0_r), .dout(s_d1)
  );

  logic [15:0] np_c, off_c, e_c;
  logic [32:0] ew_c, es_c;
  logic [17:0] n3_c;
  logic [31:0] m_r;
  logic [15:0] np_r, e_r;

  always_comb begin
    np_c = (quo1[15:0] == 16'd0) ? 16'd1 : quo1[15:0];
    n3_c = 18'(np_c) * 18'd3;
    case (mode_r)
      MODE_TRI:   off_c = n3_c[17:2];
      MODE_PULSE: off_c = np_c;
      MODE_SAW:   off_c = np_c >> 1;
      default:    off_c = 16'd0;
    endcase
    ew_c = 33'(np_c) * 33'(wcl);
    es_c = 33'(np_c) * 33'(18'(wcl) + 18'd32768);
    if (mode_r == MODE_SAW) begin
      e_c = (es_c[32:16] > 17'd65535) ? 16'hFFFF : es_c[31:16];
    end else begin
      e_c = ew_c[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= s_d1 + 32'(off_c);
      np_r <= np_c;
      e_r  <= e_c;
    end
  end

  logic [15:0] n_a, np_d2, e_d2;

  mwo_div #(.NW(32), .DW(16), .QW(32)) u_div_n (
    .clk(clk), .en(en), .num(m_r), .den(np_r), .quo(), .rem(n_a)
  );

  mwo_delay #(.W(32), .DEPTH(32)) u_nedly (
    .clk(clk), .rst_n(rst_n), .en(en), .din({np_r, e_r}), .dout({np_d2, e_d2})
  );

  logic [IB-1:0] pt_i;
  logic [15:0]   pt_rem;
  logic [15:0]   n_d3, np_d3, e_d3;

  mwo_div #(.NW(TW), .DW(16), .QW(IB)) u_div_pt (
    .clk(clk), .en(en), .num(TW'(n_a) * PTS), .den(np_d2),
    .quo(pt_i), .rem(pt_rem)
  );

  mwo_delay #(.W(48), .DEPTH(IB)) u_ptdly (
    .clk(clk), .rst_n(rst_n), .en(en), .din({n_a, np_d2, e_d2}),
    .dout({n_d3, np_d3, e_d3})
  );

  logic [IB-1:0]      pt_j;
  logic [7:0]         ba, bb;
  logic signed [17:0] va, vb;
  logic signed [17:0] a_c, d_c;
  logic [15:0]        k_c, dn_c;
  logic signed [17:0] a_r, d_r;
  logic [15:0]        k_r, dn_r;

  always_comb begin
    pt_j = (pt_i == LAST) ? '0 : pt_i + 1'b1;
    ba   = ul[8*4'(pt_i) +: 8];
    bb   = ul[8*4'(pt_j) +: 8];
    va   = (18'sd64 - $signed({10'd0, ba})) <<< 9;
    vb   = (18'sd64 - $signed({10'd0, bb})) <<< 9;
    a_c  = '0;
    d_c  = '0;
    k_c  = '0;
    dn_c = 16'd1;
    case (mode_r)
      MODE_TRI: begin
        if (n_d3 < e_d3) begin
          a_c  = vmin;
          d_c  = vmax - vmin;
          k_c  = n_d3;
          dn_c = e_d3;
        end else begin
          a_c  = vmax;
          d_c  = vmin - vmax;
          k_c  = n_d3 - e_d3;
          dn_c = np_d3 - e_d3;
        end
      end
      MODE_PULSE: begin
        a_c = (n_d3 < e_d3) ? vmin : vmax;
      end
      MODE_SAW: begin
        a_c = vmax;
        if (n_d3 < e_d3) begin
          d_c  = vmin - vmax;
          k_c  = n_d3;
          dn_c = e_d3;
        end
      end
      MODE_USER: begin
        a_c  = va;
        d_c  = vb - va;
        k_c  = pt_rem;
        dn_c = np_d3;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_c;
      d_r  <= d_c;
      k_r  <= k_c;
      dn_r <= dn_c;
    end
  end

  logic [17:0]        dmag;
  logic [33:0]        mag_r;
  logic               neg_r;
  logic signed [17:0] a2_r;
  logic [15:0]        dn2_r;

  assign dmag = d_r[17] ? 18'(-d_r) : 18'(d_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= 34'(dmag) * 34'(k_r);
      neg_r <= d_r[17];
      a2_r  <= a_r;
      dn2_r <= dn_r;
    end
  end

  logic [33:0]        qa;
  logic signed [17:0] a_d4;
  logic               neg_d4;
  logic signed [19:0] ya_sum;
  logic signed [17:0] ya, ya_d;

  mwo_div #(.NW(34), .DW(16), .QW(34)) u_div_y (
    .clk(clk), .en(en), .num(mag_r), .den(dn2_r), .quo(qa), .rem()
  );

  mwo_delay #(.W(19), .DEPTH(34)) u_ydly (
    .clk(clk), .rst_n(rst_n), .en(en), .din({a2_r, neg_r}), .dout({a_d4, neg_d4})
  );

  // the interpolated step never exceeds the span, so 18 quotient bits do
  always_comb begin
    ya_sum = neg_d4 ? 20'(a_d4) - $signed({2'b00, qa[17:0]})
                    : 20'(a_d4) + $signed({2'b00, qa[17:0]});
    if (ya_sum > 20'sd131071) begin
      ya = 18'sd131071;
    end else if (ya_sum < -20'sd131072) begin
      ya = -18'sd131072;
    end else begin
      ya = 18'(ya_sum);
    end
  end

  mwo_delay #(.W(18), .DEPTH(LAT_B - LAT_A)) u_yadly (
    .clk(clk), .rst_n(rst_n), .en(en), .din(ya), .dout(ya_d)
  );

  // ---------------- sine blend ----------------
  logic [21:0] r0;
  logic [19:0] p_d1;
  logic [41:0] pr_r;
  logic [21:0] r1;

  mwo_div #(.NW(32), .DW(22), .QW(32)) u_div_r0 (
    .clk(clk), .en(en), .num(s0_r), .den(dv), .quo(), .rem(r0)
  );

  mwo_delay #(.W(20), .DEPTH(32)) u_pdly (
    .clk(clk), .rst_n(rst_n), .en(en), .din(p0_r), .dout(p_d1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r <= 42'(p_d1) * 42'(r0);
    end
  end

  mwo_div #(.NW(42), .DW(22), .QW(42)) u_div_r1 (
    .clk(clk), .en(en), .num(pr_r), .den(dv), .quo(), .rem(r1)
  );

  logic [21:0]        rh [16];
  logic [15:0]        ph [16];
  logic signed [16:0] sn [16];
  logic signed [25:0] sl_r [16];
  logic signed [27:0] s1_r [4];
  logic signed [29:0] s2_r;

  for (genvar h = 0; h < 16; h++) begin : g_harm
    logic [15:0] ph_g;
    mwo_div #(.NW(26), .DW(22), .QW(4)) u_div_h (
      .clk(clk), .en(en), .num(26'(r1) * 26'(h + 1)), .den(dv), .quo(), .rem(rh[h])
    );
    mwo_div #(.NW(38), .DW(22), .QW(16)) u_div_ph (
      .clk(clk), .en(en), .num({rh[h], 16'd0}), .den(dv), .quo(ph[h]), .rem()
    );
    assign ph_g = (rate_r == 18'd0) ? 16'd0 : ph[h];
    mwo_sine u_sine (
      .clk(clk), .en(en), .phase(ph_g), .sine(sn[h])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sl_r[h] <= 26'(sn[h]) * $signed({18'd0, hl[8*h +: 8]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 4; g++) begin
        s1_r[g] <= 28'(sl_r[4*g]) + 28'(sl_r[4*g+1])
                 + 28'(sl_r[4*g+2]) + 28'(sl_r[4*g+3]);
      end
      s2_r <= 30'(s1_r[0]) + 30'(s1_r[1]) + 30'(s1_r[2]) + 30'(s1_r[3]);
    end
  end

  // blend = -(weighted sum)/tot_r, so a positive sum gives a negative word
  logic [29:0]        smag;
  logic [29:0]        qb;
  logic               nb_d;
  logic signed [17:0] yb;

  assign smag = s2_r[29] ? 30'(-s2_r) : 30'(s2_r);

  mwo_div #(.NW(30), .DW(12), .QW(30)) u_div_b (
    .clk(clk), .en(en), .num(smag), .den(tot_r), .quo(qb), .rem()
  );

  mwo_delay #(.W(1), .DEPTH(30)) u_nbdly (
    .clk(clk), .rst_n(rst_n), .en(en), .din(!s2_r[29]), .dout(nb_d)
  );

  always_comb begin
    if (tot_r == 12'd0) begin
      yb = '0;
    end else begin
      yb = nb_d ? -$signed(qb[17:0]) : $signed(qb[17:0]);
    end
  end

  // ---------------- output register ----------------
  logic signed [17:0] y_c;

  always_comb begin
    case (mode_r)
      MODE_SINE:  y_c = yb;
      MODE_TRI,
      MODE_PULSE,
      MODE_SAW,
      MODE_USER:  y_c = ya_d;
      default:    y_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= y_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level_out = out_r;

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v0_r))
    else $error("input stage moved during a stall");

  a_unused_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_r > MODE_USER)
      |-> out_level_out == 18'sd0)
    else $error("unused mode gave a non-zero word");

  a_pulse_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == MODE_PULSE
      |-> (out_level_out == vmin || out_level_out == vmax))
    else $error("pulse word is neither level");

  a_ready_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output word is stuck");
`endif

endmodule
